[rtl/swhc_pkg.sv]
// Shared types and constants for the sliding window hit counter.
// No dependencies; swhc_mod and the hit counter unit import this package.
package swhc_pkg;

  // Field widths of the stream payload.
  localparam int unsigned TimeW  = 31;
  localparam int unsigned CountW = 16;
  localparam int unsigned SumW   = 25;

  // Window length in seconds, which is also the number of buckets.
  localparam int unsigned Window = 300;
  localparam int unsigned IdxW   = $clog2(Window);

  // Saturation limits.
  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};
  localparam logic [SumW-1:0]   SumMax   = {SumW{1'b1}};

  // Operation carried in tuser.
  typedef enum logic {
    OP_HIT   = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  // Controller states.
  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_MOD,
    ST_SWEEP,
    ST_TAIL,
    ST_FINISH
  } state_e;

  // One bucket as it is stored in the memory.
  typedef struct packed {
    logic [CountW-1:0] count;
    logic [TimeW-1:0]  stamp;
  } bucket_t;

endpackage

[rtl/swhc_ram.sv]
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
module swhc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/swhc_mod.sv]
// Remainder unit: a registered pipeline reduces a time value modulo the window.
// Depends on swhc_pkg for widths and the window constant.
module swhc_mod
  import swhc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [TimeW-1:0] value_i,
  output logic             busy_o,
  output logic [IdxW-1:0]  rem_o
);

  // The upper time bits are folded onto the lower ones with 2^16 mod Window.
  // The quotient of the folded value then comes from a reciprocal product,
  // which is exact for every value below 2^FoldW.
  localparam int unsigned     LoW       = 16;
  localparam int unsigned     HiW       = TimeW - LoW;
  localparam int unsigned     FoldW     = HiW + IdxW + 1;
  localparam int unsigned     RecipW    = FoldW + 1;
  localparam int unsigned     ProdW     = FoldW + RecipW;
  localparam int unsigned     QuotShift = FoldW + IdxW;
  localparam longint unsigned FoldMul   = (64'd1 << LoW) % Window;
  localparam longint unsigned RecipMul  = ((64'd1 << QuotShift) + Window - 1) / Window;

  logic [2:0]       stage_q, stage_d;
  logic [TimeW-1:0] val_q;
  logic [FoldW-1:0] fold_q, fold_d;
  logic [ProdW-1:0] prod_q, prod_d;
  logic [FoldW-1:0] quot;
  logic [FoldW-1:0] rest;
  logic [IdxW-1:0]  rem_q, rem_d;

  // Fold, multiply by the reciprocal, then subtract the quotient multiple.
  always_comb begin
    stage_d = {stage_q[1:0], start_i};
    fold_d  = FoldW'(val_q[TimeW-1:LoW]) * FoldW'(FoldMul) + FoldW'(val_q[LoW-1:0]);
    prod_d  = ProdW'(fold_q) * ProdW'(RecipMul);
    quot    = FoldW'(prod_q[ProdW-1:QuotShift]);
    rest    = fold_q - quot * FoldW'(Window);
    rem_d   = rest[IdxW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
    end else begin
      stage_q <= stage_d;
    end
  end

  // Each step loads when the step before it has produced its value.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      val_q <= value_i;
    end
    if (stage_q[0]) begin
      fold_q <= fold_d;
    end
    if (stage_q[1]) begin
      prod_q <= prod_d;
    end
    if (stage_q[2]) begin
      rem_q <= rem_d;
    end
  end

  assign busy_o = |stage_q;
  assign rem_o  = rem_q;

endmodule

[rtl/sliding_window_hit_counter_unit.sv]
// Sliding window hit counter: bucket memory, sweep controller and output register.
// A query's sum becomes valid after a full memory sweep, and the next item is accepted
// from that same cycle on (later while the output is stalled); a hit passes through a
// remainder step, one memory sweep and a final write-back.
// After reset a clearing pass writes zero to every bucket; no input
// transaction is accepted until it finishes.
module sliding_window_hit_counter_unit
  import swhc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [30:0] now_seconds, [31] zero
  input  logic [0:0]  s_axis_tuser_i,   // [0] op
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o    // [24:0] window_hits, [31:25] zero
);

  state_e            state_q, state_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic [IdxW-1:0]   wr_idx_q;
  logic              rd_vld_q;
  op_e               op_q;
  logic [TimeW-1:0]  now_q;
  logic [SumW-1:0]   sum_q, sum_d;
  logic              out_vld_q, out_vld_d;
  logic [SumW-1:0]   out_data_q;
  logic              in_acc, out_load;

  logic              mem_we, mem_re;
  logic [IdxW-1:0]   mem_waddr;
  bucket_t           mem_wdata, mem_rdata, upd;
  logic              mod_busy;
  logic [IdxW-1:0]   slot;
  logic              stale;
  logic [SumW:0]     sum_ext;

  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;

  // Remainder unit finds the bucket slot of a hit.
  swhc_mod u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_acc && (op_e'(s_axis_tuser_i[0]) == OP_HIT)),
    .value_i (s_axis_tdata_i[TimeW-1:0]),
    .busy_o  (mod_busy),
    .rem_o   (slot)
  );

  // Bucket memory.
  swhc_ram #(
    .Width ($bits(bucket_t)),
    .Depth (Window)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (idx_q),
    .rdata_o (mem_rdata)
  );

  // Read-modify-write of the bucket read in the previous cycle.
  always_comb begin
    stale = ({1'b0, now_q} >= ({1'b0, mem_rdata.stamp} + (TimeW+1)'(Window)));
    upd   = mem_rdata;
    if (stale) begin
      upd = '0;
    end
    if (wr_idx_q == slot) begin
      if (upd.stamp == now_q) begin
        if (upd.count != CountMax) begin
          upd.count = upd.count + 1'b1;
        end
      end else begin
        upd.count = CountW'(1);
        upd.stamp = now_q;
      end
    end
  end

  // Saturating accumulation for a query.
  always_comb begin
    sum_ext = {1'b0, sum_q} + (SumW+1)'(mem_rdata.count);
    sum_d   = sum_q;
    if (in_acc) begin
      sum_d = '0;
    end else if (rd_vld_q && (op_q == OP_QUERY) && !stale) begin
      sum_d = (sum_ext > (SumW+1)'(SumMax)) ? SumMax : sum_ext[SumW-1:0];
    end
  end

  // Memory port control.
  always_comb begin
    mem_re = (state_q == ST_SWEEP);
    if (state_q == ST_INIT) begin
      mem_we    = 1'b1;
      mem_waddr = idx_q;
      mem_wdata = '0;
    end else begin
      mem_we    = rd_vld_q && (op_q == OP_HIT);
      mem_waddr = wr_idx_q;
      mem_wdata = upd;
    end
  end

  // Next state and sweep index.
  always_comb begin
    state_d         = state_q;
    idx_d           = idx_q;
    s_axis_tready_o = 1'b0;
    out_load        = 1'b0;
    unique case (state_q)
      ST_INIT: begin
        idx_d = idx_q + 1'b1;
        if (idx_q == IdxW'(Window - 1)) begin
          idx_d   = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        idx_d           = '0;
        if (s_axis_tvalid_i) begin
          state_d = (op_e'(s_axis_tuser_i[0]) == OP_HIT) ? ST_MOD : ST_SWEEP;
        end
      end
      ST_MOD: begin
        if (!mod_busy) begin
          state_d = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        idx_d = idx_q + 1'b1;
        if (idx_q == IdxW'(Window - 1)) begin
          idx_d   = '0;
          state_d = ST_TAIL;
        end
      end
      ST_TAIL: begin
        state_d = (op_q == OP_HIT) ? ST_IDLE : ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_vld_q || m_axis_tready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output register.
  always_comb begin
    out_vld_d = out_vld_q;
    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_INIT;
      idx_q     <= '0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      rd_vld_q  <= (state_q == ST_SWEEP);
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    wr_idx_q <= idx_q;
    sum_q    <= sum_d;
    if (in_acc) begin
      op_q  <= op_e'(s_axis_tuser_i[0]);
      now_q <= s_axis_tdata_i[TimeW-1:0];
    end
    if (out_load) begin
      out_data_q <= sum_q;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {{(32 - SumW){1'b0}}, out_data_q};

  // The memory is written only by the clearing pass or while a hit is swept.
  a_write_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == ST_INIT) || (op_q == OP_HIT))
    else $error("bucket write outside clearing pass or hit");

  // The sweep index stays inside the bucket range.
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= IdxW'(Window - 1))
    else $error("sweep index out of range");

  // A new result appears only when a query sweep has finished.
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(state_q == ST_FINISH))
    else $error("result without finished query");

  // The remainder unit runs only while the controller waits for it.
  a_mod_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_busy |-> (state_q == ST_MOD))
    else $error("remainder unit busy outside its phase");

endmodule
